@@ src/day_profile_sun_hours_macros.svh @@
// ----------------------------------------------------------------------------
// day_profile_sun_hours_macros
// assertion macros used by the checker file dpsh_checker
// ----------------------------------------------------------------------------
`ifndef DAY_PROFILE_SUN_HOURS_MACROS_SVH
`define DAY_PROFILE_SUN_HOURS_MACROS_SVH

// implication checked at every clock edge outside reset
`define DPSH_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same, but the consequent is checked in the cycle after the antecedent
`define DPSH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/dpsh_pkg.sv @@
// ----------------------------------------------------------------------------
// dpsh_pkg
// widths, constants and controller/datapath command type for the day profile
// ----------------------------------------------------------------------------
package dpsh_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DAY_HOURS   = 24;
  localparam int HOUR_BITS   = 5;
  localparam int TMAX_BITS   = 12;

  localparam logic [HOUR_BITS-1:0] LAST_HOUR      = HOUR_BITS'(DAY_HOURS - 1);
  localparam logic [TMAX_BITS-1:0] CENTI_PER_HOUR = TMAX_BITS'(100);
  localparam logic [TMAX_BITS-1:0] TMAX_SLOPE     = TMAX_BITS'(33);
  localparam logic [TMAX_BITS-1:0] DAY_CENTI      = TMAX_BITS'(100 * DAY_HOURS);

  typedef struct packed {
    logic                 load;     // take a sample beat
    logic [HOUR_BITS-1:0] hour;     // hour of the sample being taken
    logic                 resolve;  // settle sunrise and sunset with the wrap
    logic                 diff;     // sunset minus noon, modulo a day
    logic                 calc;     // max temperature time
  } dpsh_cmd_t;

endpackage

@@ src/dpsh_ctrl.sv @@
// ----------------------------------------------------------------------------
// dpsh_ctrl
// hour counter and end-of-day sequencer
// ----------------------------------------------------------------------------
module dpsh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output dpsh_pkg::dpsh_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RESOLVE = 3'd1;
  localparam logic [2:0] ST_DIFF    = 3'd2;
  localparam logic [2:0] ST_CALC    = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  logic [2:0]                     state;
  logic [2:0]                     state_next;
  logic [dpsh_pkg::HOUR_BITS-1:0] hour;
  logic                           accept;

  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_EMIT);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (hour == dpsh_pkg::LAST_HOUR)) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: state_next = ST_DIFF;
      ST_DIFF:    state_next = ST_CALC;
      ST_CALC:    state_next = ST_EMIT;
      ST_EMIT:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hour  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        hour <= (hour == dpsh_pkg::LAST_HOUR) ? '0 : hour + 1'b1;
      end
    end
  end

  always_comb begin
    cmd.load    = accept;
    cmd.hour    = hour;
    cmd.resolve = (state == ST_RESOLVE);
    cmd.diff    = (state == ST_DIFF);
    cmd.calc    = (state == ST_CALC);
  end

endmodule

@@ src/dpsh_datapath.sv @@
// ----------------------------------------------------------------------------
// dpsh_datapath
// running compares over the day's samples and end-of-day arithmetic
// ----------------------------------------------------------------------------
module dpsh_datapath (
  input  logic                                 clk,
  input  dpsh_pkg::dpsh_cmd_t                  cmd,
  input  logic [dpsh_pkg::SAMPLE_BITS-1:0]     sample,
  output logic [dpsh_pkg::HOUR_BITS-1:0]       sunrise_hour,
  output logic                                 sunrise_found,
  output logic [dpsh_pkg::HOUR_BITS-1:0]       noon_hour,
  output logic [dpsh_pkg::HOUR_BITS-1:0]       sunset_hour,
  output logic                                 sunset_found,
  output logic [dpsh_pkg::TMAX_BITS-1:0]       tmax_centihours
);

  logic [dpsh_pkg::SAMPLE_BITS-1:0] first_s;
  logic [dpsh_pkg::SAMPLE_BITS-1:0] prev_s;
  logic [dpsh_pkg::SAMPLE_BITS-1:0] max_s;
  logic                             rise_prev;
  logic                             rise1;
  logic [dpsh_pkg::HOUR_BITS-1:0]   cand_h;
  logic                             cand_ok;
  logic [dpsh_pkg::HOUR_BITS-1:0]   fall_h;
  logic                             fall_ok;
  logic [dpsh_pkg::HOUR_BITS-1:0]   diff_h;

  logic                             rise_now;
  logic                             fall_now;
  logic                             rise0;
  logic                             fall0;
  logic [dpsh_pkg::HOUR_BITS:0]     diff_wide;
  logic [dpsh_pkg::TMAX_BITS-1:0]   tmax_sum;

  assign rise_now = sample > prev_s;
  assign fall_now = prev_s > sample;
  // hour 0 against hour 23, known once the day is complete
  assign rise0    = first_s > prev_s;
  assign fall0    = prev_s > first_s;

  assign diff_wide = {1'b0, sunset_hour} + (dpsh_pkg::HOUR_BITS+1)'(dpsh_pkg::DAY_HOURS)
                   - {1'b0, noon_hour};
  assign tmax_sum  = ({{(dpsh_pkg::TMAX_BITS-dpsh_pkg::HOUR_BITS){1'b0}}, noon_hour}
                      * dpsh_pkg::CENTI_PER_HOUR)
                   + ({{(dpsh_pkg::TMAX_BITS-dpsh_pkg::HOUR_BITS){1'b0}}, diff_h}
                      * dpsh_pkg::TMAX_SLOPE);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev_s <= sample;
      if (cmd.hour == '0) begin
        first_s   <= sample;
        max_s     <= sample;
        noon_hour <= '0;
        cand_ok   <= 1'b0;
        fall_ok   <= 1'b0;
      end else begin
        rise_prev <= rise_now;
        if (cmd.hour == dpsh_pkg::HOUR_BITS'(1)) begin
          rise1 <= rise_now;
        end else if (rise_now && !rise_prev && !cand_ok) begin
          // first rise after a non-rise from hour 2 on
          cand_h  <= cmd.hour;
          cand_ok <= 1'b1;
        end
        if (fall_now) begin
          fall_h  <= cmd.hour;
          fall_ok <= 1'b1;
        end
        if (max_s < sample) begin
          max_s     <= sample;
          noon_hour <= cmd.hour;
        end
      end
    end

    if (cmd.resolve) begin
      priority if (rise1 && !rise0) begin
        sunrise_hour  <= dpsh_pkg::HOUR_BITS'(1);
        sunrise_found <= 1'b1;
      end else if (cand_ok) begin
        sunrise_hour  <= cand_h;
        sunrise_found <= 1'b1;
      end else begin
        sunrise_hour  <= '0;
        sunrise_found <= rise0;
      end
      priority if (fall_ok) begin
        sunset_hour  <= fall_h;
        sunset_found <= 1'b1;
      end else begin
        sunset_hour  <= '0;
        sunset_found <= fall0;
      end
    end

    if (cmd.diff) begin
      diff_h <= (diff_wide >= (dpsh_pkg::HOUR_BITS+1)'(dpsh_pkg::DAY_HOURS))
              ? dpsh_pkg::HOUR_BITS'(diff_wide - (dpsh_pkg::HOUR_BITS+1)'(dpsh_pkg::DAY_HOURS))
              : diff_wide[dpsh_pkg::HOUR_BITS-1:0];
    end

    if (cmd.calc) begin
      // sum stays below two days, one subtract wraps it
      tmax_centihours <= (tmax_sum >= dpsh_pkg::DAY_CENTI) ? tmax_sum - dpsh_pkg::DAY_CENTI
                                                          : tmax_sum;
    end
  end

endmodule

@@ src/day_profile_sun_hours.sv @@
// ----------------------------------------------------------------------------
// day_profile_sun_hours
// sunrise, noon, sunset and max temperature time from 24 hourly samples
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  sample   | start / busy       | sample
//  result   | done (one cycle)   | sunrise_hour, sunrise_found, noon_hour,
//           |                    | sunset_hour, sunset_found, tmax_centihours
//
//  one sample beat per cycle while busy is low; each beat updates running
//  compares against the previous sample, so no sample store is kept
//  after the 24th beat busy stays high through the wrap resolve, hour
//  difference, tmax and result states; done is high in the last of them
//  rst is synchronous and returns the hour counter to the first hour
//  the result cannot be stalled: it is shown for exactly one cycle
// ----------------------------------------------------------------------------
module day_profile_sun_hours (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [dpsh_pkg::SAMPLE_BITS-1:0]   sample,
  output logic                               busy,
  output logic                               done,
  output logic [dpsh_pkg::HOUR_BITS-1:0]     sunrise_hour,
  output logic                               sunrise_found,
  output logic [dpsh_pkg::HOUR_BITS-1:0]     noon_hour,
  output logic [dpsh_pkg::HOUR_BITS-1:0]     sunset_hour,
  output logic                               sunset_found,
  output logic [dpsh_pkg::TMAX_BITS-1:0]     tmax_centihours
);

  dpsh_pkg::dpsh_cmd_t cmd;

  dpsh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  dpsh_datapath u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .sample          (sample),
    .sunrise_hour    (sunrise_hour),
    .sunrise_found   (sunrise_found),
    .noon_hour       (noon_hour),
    .sunset_hour     (sunset_hour),
    .sunset_found    (sunset_found),
    .tmax_centihours (tmax_centihours)
  );

endmodule

@@ src/dpsh_checker.sv @@
// ----------------------------------------------------------------------------
// dpsh_checker
// port-level checks on the result strobe and result ranges
// ----------------------------------------------------------------------------
`include "day_profile_sun_hours_macros.svh"

module dpsh_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic [dpsh_pkg::SAMPLE_BITS-1:0]   sample,
  input logic                               busy,
  input logic                               done,
  input logic [dpsh_pkg::HOUR_BITS-1:0]     sunrise_hour,
  input logic                               sunrise_found,
  input logic [dpsh_pkg::HOUR_BITS-1:0]     noon_hour,
  input logic [dpsh_pkg::HOUR_BITS-1:0]     sunset_hour,
  input logic                               sunset_found,
  input logic [dpsh_pkg::TMAX_BITS-1:0]     tmax_centihours
);

  logic unused_in;
  assign unused_in = start ^ (^sample);

  // a result beat is a single cycle and frees the input right after
  `DPSH_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy, "done not a one-cycle pulse")
  // no sample beat can be taken while a result is shown
  `DPSH_ASSERT(a_done_busy, clk, rst, done |-> busy, "result shown while idle")
  `DPSH_ASSERT(a_ranges, clk, rst,
    done |-> (sunrise_hour < 5'd24) && (noon_hour < 5'd24) && (sunset_hour < 5'd24)
             && (tmax_centihours < 12'd2400),
    "result field out of range")
  `DPSH_ASSERT(a_not_found, clk, rst,
    done |-> (sunrise_found || (sunrise_hour == 5'd0)) && (sunset_found || (sunset_hour == 5'd0)),
    "hour not zero when not found")

endmodule

bind day_profile_sun_hours dpsh_checker u_dpsh_checker (.*);
